// ===== rtl/rhb_pkg.sv =====
`default_nettype none

package rhb_pkg;

  localparam int MAX_BINS_DEF = 256;

  localparam int SAMPLE_W = 32;
  localparam int BIN_CNT_W = 9;
  localparam int RANGE_W = 31;
  localparam int DEN_W = RANGE_W + 1;
  localparam int COUNT_W = 32;
  localparam int INDEX_W = 8;
  localparam int NUM_W = DEN_W + BIN_CNT_W;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = RANGE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_RANGE = 1'd1;

  localparam logic [BIN_CNT_W-1:0] BIN_COUNT_RST = 9'd256;
  localparam logic [RANGE_W-1:0] FULL_RANGE_RST = 31'd131072;

  // one classified word between front and back
  typedef struct packed {
    logic hit;
    logic [NUM_W-1:0] num;
  } rhb_work_t;

endpackage

`default_nettype wire

// ===== rtl/rhb_in_if.sv =====
`default_nettype none

interface rhb_in_if;
  logic valid;
  logic ready;
  logic signed [rhb_pkg::SAMPLE_W-1:0] sample_value;

  modport source(output valid, output sample_value, input ready);
  modport sink(input valid, input sample_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/rhb_out_if.sv =====
`default_nettype none

interface rhb_out_if;
  logic valid;
  logic ready;
  logic [rhb_pkg::INDEX_W-1:0] bin_index;
  logic in_range;
  logic [rhb_pkg::COUNT_W-1:0] count_after;

  modport source(output valid, output bin_index, output in_range, output count_after,
                 input ready);
  modport sink(input valid, input bin_index, input in_range, input count_after,
               output ready);
endinterface

`default_nettype wire

// ===== rtl/range_histogram_binner_core.sv =====
// channel   dir  payload                                  accepted when
// in_chan   in   sample_value (s32, Q16.16)               valid && ready
// out_chan  out  bin_index (u8), in_range, count_after    valid && ready
// cfg       in   cfg_idx, cfg_data (bin_count, full_range) cfg_we
//
// front: classifies a word through registers t_r (offset) and num_r (multiply),
// with the range compare on the way into a 2-word queue. back: an out-of-range
// word goes straight to the update state; a counted word runs a restoring divide
// (one quotient bit per cycle), a counter read, then the update. after reset the
// counter memory is swept to zero with in_chan.ready low. a stalled output holds the back; the front keeps filling.
`default_nettype none

module range_histogram_binner_core #(
  parameter int MAX_BINS = rhb_pkg::MAX_BINS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  rhb_in_if.sink                                in_chan,
  rhb_out_if.source                             out_chan,
  input  wire logic                             cfg_we,
  input  wire logic [rhb_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [rhb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import rhb_pkg::*;

  logic [BIN_CNT_W-1:0] bin_count_r;
  logic [RANGE_W-1:0]   full_range_r;
  logic                 clearing;
  logic                 f_valid;
  logic                 f_ready;
  rhb_work_t            f_data;
  logic                 b_valid;
  logic                 b_ready;
  rhb_work_t            b_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r <= BIN_COUNT_RST;
      full_range_r <= FULL_RANGE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_BIN_COUNT: bin_count_r <= cfg_data[BIN_CNT_W-1:0];
        CFG_FULL_RANGE: full_range_r <= cfg_data[RANGE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rhb_front #(
    .MAX_BINS(MAX_BINS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .sample_value(in_chan.sample_value),
    .bin_count   (bin_count_r),
    .full_range  (full_range_r),
    .hold        (clearing),
    .q_valid     (f_valid),
    .q_ready     (f_ready),
    .q_data      (f_data)
  );

  rhb_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_data  (f_data),
    .out_valid(b_valid),
    .out_ready(b_ready),
    .out_data (b_data)
  );

  rhb_back #(
    .MAX_BINS(MAX_BINS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (b_valid),
    .q_ready    (b_ready),
    .q_data     (b_data),
    .den        ({full_range_r, 1'b0}),
    .clearing   (clearing),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .bin_index  (out_chan.bin_index),
    .in_range   (out_chan.in_range),
    .count_after(out_chan.count_after)
  );

endmodule

`default_nettype wire

// ===== rtl/rhb_ram.sv =====
`default_nettype none

module rhb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/rhb_front.sv =====
`default_nettype none

module rhb_front #(
  parameter int MAX_BINS = rhb_pkg::MAX_BINS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [rhb_pkg::SAMPLE_W-1:0] sample_value,
  input  wire logic [rhb_pkg::BIN_CNT_W-1:0]       bin_count,
  input  wire logic [rhb_pkg::RANGE_W-1:0]         full_range,
  input  wire logic                                hold,
  output logic                                     q_valid,
  input  wire logic                                q_ready,
  output rhb_pkg::rhb_work_t                       q_data
);

  import rhb_pkg::*;

  logic                       v1_r;
  logic                       v2_r;
  logic signed [SAMPLE_W+1:0] t_r;
  logic signed [NUM_W+2:0]    num_r;
  logic [NUM_W-1:0]           den_lim_r;
  logic [DEN_W-1:0]           den;
  logic [BIN_CNT_W-1:0]       lim;
  logic signed [NUM_W+2:0]    sum;
  logic                       accept;
  logic                       stall;
  logic                       neg_ok;
  logic                       pos_ok;

  assign den = {full_range, 1'b0};
  assign lim = ({23'd0, bin_count} > 32'(MAX_BINS)) ? BIN_CNT_W'(MAX_BINS) : bin_count;

  assign stall = v2_r && !q_ready;
  assign in_ready = !hold && (!v1_r || !stall);
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept || (v1_r && stall);
      if (!stall) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      t_r <= $signed({sample_value[SAMPLE_W-1], sample_value, 1'b0})
           + $signed({3'b000, full_range});
    end
    if (!stall && v1_r) begin
      num_r <= t_r * $signed({1'b0, bin_count});
    end
    den_lim_r <= den * lim;
  end

  // truncation toward zero keeps slightly negative positions in bin 0
  assign sum = num_r + $signed({12'd0, den});
  assign neg_ok = num_r[NUM_W+2] && !sum[NUM_W+2] && (sum != '0) && (lim != '0);
  assign pos_ok = !num_r[NUM_W+2] && (num_r[NUM_W+1:0] < {2'b00, den_lim_r});

  assign q_valid = v2_r;
  assign q_data.hit = neg_ok || pos_ok;
  assign q_data.num = pos_ok ? num_r[NUM_W-1:0] : '0;

endmodule

`default_nettype wire

// ===== rtl/rhb_fifo.sv =====
`default_nettype none

module rhb_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rhb_pkg::rhb_work_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rhb_pkg::rhb_work_t      out_data
);

  import rhb_pkg::*;

  rhb_work_t   ent_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        push;
  logic        pop;

  assign in_ready = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data = ent_r[rd_ptr_r];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rhb_back.sv =====
`default_nettype none

module rhb_back #(
  parameter int MAX_BINS = rhb_pkg::MAX_BINS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  output logic                               q_ready,
  input  wire rhb_pkg::rhb_work_t            q_data,
  input  wire logic [rhb_pkg::DEN_W-1:0]     den,
  output logic                               clearing,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [rhb_pkg::INDEX_W-1:0]        bin_index,
  output logic                               in_range,
  output logic [rhb_pkg::COUNT_W-1:0]        count_after
);

  import rhb_pkg::*;

  localparam int IW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CW = (IW > 1) ? $clog2(IW) : 1;
  localparam int WW = DEN_W + IW;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_UPD
  } state_t;

  state_t             state_r;
  logic [IW-1:0]      clr_r;
  logic [IW-1:0]      quo_r;
  logic [CW-1:0]      step_r;
  logic [WW-1:0]      rem_r;
  logic [WW-1:0]      dsh_r;
  logic               hit_r;
  logic               out_valid_r;
  logic [INDEX_W-1:0] bin_index_r;
  logic               in_range_r;
  logic [COUNT_W-1:0] count_r;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [COUNT_W-1:0] ram_wdata;
  logic [COUNT_W-1:0] ram_rdata;
  logic [COUNT_W-1:0] cnt_inc;
  logic               ge;
  logic               out_free;
  logic               pop;

  assign ge = (rem_r >= dsh_r);
  assign out_free = !out_valid_r || out_ready;
  assign q_ready = (state_r == ST_IDLE);
  assign pop = q_valid && q_ready;
  assign clearing = (state_r == ST_CLEAR);
  assign cnt_inc = (&ram_rdata) ? ram_rdata : ram_rdata + COUNT_W'(1);

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = quo_r;
    ram_wdata = cnt_inc;
    case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      ST_UPD: begin
        ram_we = hit_r && out_free;
      end
      default: begin
      end
    endcase
  end

  rhb_ram #(
    .WIDTH(COUNT_W),
    .DEPTH(MAX_BINS)
  ) u_counts (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(quo_r),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_UPD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + IW'(1);
          if (clr_r == IW'(MAX_BINS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop) begin
            hit_r <= q_data.hit;
            rem_r <= WW'(q_data.num);
            dsh_r <= {IW'(0), den} << (IW - 1);
            quo_r <= '0;
            step_r <= CW'(IW - 1);
            state_r <= q_data.hit ? ST_DIV : ST_UPD;
          end
        end
        ST_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (ge) begin
            rem_r <= rem_r - dsh_r;
          end
          dsh_r <= dsh_r >> 1;
          quo_r <= (quo_r << 1) | IW'(ge);
          step_r <= step_r - CW'(1);
          if (step_r == '0) begin
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          if (out_free) begin
            in_range_r <= hit_r;
            bin_index_r <= hit_r ? INDEX_W'(quo_r) : '0;
            count_r <= hit_r ? cnt_inc : '0;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign bin_index = bin_index_r;
  assign in_range = in_range_r;
  assign count_after = count_r;

endmodule

`default_nettype wire

// ===== test/tb_range_histogram_binner_core.sv =====
`timescale 1ns / 1ps

module tb_range_histogram_binner_core;
  import rhb_pkg::*;

  localparam int TALLY_DEPTH = MAX_BINS_DEF;
  localparam int QUIET_LIMIT = 3000;
  localparam int PHASE_ITEMS = 136;

  typedef struct packed {
    logic [INDEX_W-1:0] bin_index;
    logic in_range;
    logic [COUNT_W-1:0] count_after;
  } bin_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  rhb_in_if in_if();
  rhb_out_if out_if();

  range_histogram_binner_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_if.sink),
    .out_chan(out_if.source),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  logic [SAMPLE_W-1:0] sample_queue[$];
  bin_result_t bin_results_due[$];
  logic [COUNT_W-1:0] tallies[TALLY_DEPTH];
  logic [BIN_CNT_W-1:0] bins_cfg;
  logic [RANGE_W-1:0] range_cfg;
  logic steady = 1'b0;
  int errors = 0;
  int quiet_cycles = 0;

  function automatic bin_result_t tally_sample(input logic signed [SAMPLE_W-1:0] s);
    longint num;
    longint den;
    longint pos;
    bin_result_t r;
    r = '0;
    if (range_cfg != '0 && bins_cfg != '0) begin
      num = (2 * longint'(s) + longint'(range_cfg)) * longint'(bins_cfg);
      den = 2 * longint'(range_cfg);
      pos = num / den;
      if (pos >= 0 && pos < longint'(bins_cfg) && pos < TALLY_DEPTH) begin
        if (tallies[pos] != '1) tallies[pos] = tallies[pos] + COUNT_W'(1);
        r.bin_index = pos[INDEX_W-1:0];
        r.in_range = 1'b1;
        r.count_after = tallies[pos];
      end
    end
    return r;
  endfunction

  // mostly inside the range, some on bin edges, the rest anywhere
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned roll;
    longint span;
    longint half;
    longint s;
    roll = $urandom_range(0, 99);
    span = longint'(range_cfg);
    half = span / 2;
    s = longint'($urandom);
    if (span != 0 && roll < 65) begin
      s = (longint'($urandom) % span) - half;
    end else if (span != 0 && bins_cfg != '0 && roll < 85) begin
      s = (longint'($urandom_range(0, bins_cfg)) * span) / longint'(bins_cfg) - half
          + longint'($urandom_range(0, 6)) - 3;
    end
    return s[SAMPLE_W-1:0];
  endfunction

  function automatic logic idle_now();
    return !steady && ($urandom_range(0, 99) < 22);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t %s: got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic settle();
    do @(negedge clk);
    while (sample_queue.size() != 0 || in_if.valid || bin_results_due.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    if (idx == CFG_BIN_COUNT) bins_cfg = data[BIN_CNT_W-1:0];
    else if (idx == CFG_FULL_RANGE) range_cfg = data[RANGE_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [BIN_CNT_W-1:0] bc, input logic [RANGE_W-1:0] fr);
    settle();
    write_reg(CFG_BIN_COUNT, CFG_DATA_W'(bc));
    write_reg(CFG_FULL_RANGE, fr);
    @(negedge clk);
  endtask

  // input side: holds a word until taken, predicts each accepted word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) bin_results_due.push_back(tally_sample(in_if.sample_value));
      if (!in_if.valid || in_if.ready) begin
        if (sample_queue.size() != 0 && !idle_now()) begin
          in_if.valid <= 1'b1;
          in_if.sample_value <= sample_queue.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin : result_check
    bin_result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (bin_results_due.size() == 0) begin
          report_mismatch("unexpected word", 64'(out_if.count_after), 64'd0);
        end else begin
          want = bin_results_due.pop_front();
          if (out_if.bin_index !== want.bin_index)
            report_mismatch("bin_index", 64'(out_if.bin_index), 64'(want.bin_index));
          if (out_if.in_range !== want.in_range)
            report_mismatch("in_range", 64'(out_if.in_range), 64'(want.in_range));
          if (out_if.count_after !== want.count_after)
            report_mismatch("count_after", 64'(out_if.count_after), 64'(want.count_after));
        end
      end
      out_if.ready <= !idle_now();
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned roll;
    logic [BIN_CNT_W-1:0] bc;
    logic [RANGE_W-1:0] fr;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    bins_cfg = BIN_COUNT_RST;
    range_cfg = FULL_RANGE_RST;
    foreach (tallies[i]) tallies[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset setting: 256 bins over [-1.0, 1.0)
    sample_queue = '{32'sd0, -32'sd65536, -32'sd65537, -32'sd66047, -32'sd66048,
                     32'sd65535, 32'sd65536, 32'h7FFFFFFF, 32'h80000000, 32'sd0,
                     -32'sd65536};
    // one bin, smallest range
    configure(9'd1, 31'd1);
    sample_queue = '{32'sd0, -32'sd1, 32'sd1, -32'sd2};
    // bins beyond the counter store, widest range
    configure(9'd511, 31'h7FFFFFFF);
    sample_queue = '{32'sd0, 32'h7FFFFFFF, 32'h80000000, 32'hC0000000, 32'h3FFFFFFF};
    // no bins in use
    configure(9'd0, 31'd131072);
    sample_queue = '{32'sd0, 32'sd1};
    // zero range
    configure(9'd300, 31'd0);
    sample_queue = '{32'sd0, 32'sd65535};

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 0) begin
        bc = BIN_COUNT_RST;
        fr = FULL_RANGE_RST;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 35) bc = 9'($urandom_range(1, 256));
        else if (roll < 60) bc = 9'($urandom_range(1, 16));
        else if (roll < 75) bc = 9'd256;
        else if (roll < 92) bc = 9'($urandom_range(257, 511));
        else bc = 9'd0;
        roll = $urandom_range(0, 99);
        if (roll < 40) fr = 31'($urandom_range(1, 1 << 20));
        else if (roll < 70) fr = 31'($urandom);
        else if (roll < 85) fr = FULL_RANGE_RST;
        else if (roll < 95) fr = 31'($urandom_range(1, 64));
        else fr = 31'd0;
      end
      configure(bc, fr);
      steady = (ph == 0);
      repeat (PHASE_ITEMS) sample_queue.push_back(pick_sample());
    end

    settle();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== range_histogram_binner_core.f =====
rtl/rhb_pkg.sv
rtl/rhb_in_if.sv
rtl/rhb_out_if.sv
rtl/rhb_ram.sv
rtl/rhb_front.sv
rtl/rhb_fifo.sv
rtl/rhb_back.sv
rtl/range_histogram_binner_core.sv
test/tb_range_histogram_binner_core.sv
